/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while in reset.
`define STP_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sms tpdu parser check failed");

// Implication form of the above.
`define STP_ASSERT_IMP(lbl, ante, cons) \
  `STP_ASSERT_CLK(lbl, (ante) |-> (cons))

`endif

/* rtl/core/stp_pkg.sv */
`default_nettype none

package stp_pkg;

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_REF    = 4'd1;
  localparam logic [3:0] PH_ALEN   = 4'd2;
  localparam logic [3:0] PH_ATYPE  = 4'd3;
  localparam logic [3:0] PH_DIGITS = 4'd4;
  localparam logic [3:0] PH_PID    = 4'd5;
  localparam logic [3:0] PH_DCS    = 4'd6;
  localparam logic [3:0] PH_TS     = 4'd7;
  localparam logic [3:0] PH_VP     = 4'd8;
  localparam logic [3:0] PH_UDL    = 4'd9;
  localparam logic [3:0] PH_UD     = 4'd10;
  localparam logic [3:0] PH_STS    = 4'd11;
  localparam logic [3:0] PH_CMD    = 4'd12;
  localparam logic [3:0] TAG_TRAIL = 4'd13;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_SUBMIT  = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;
  localparam logic [1:0] KIND_COMMAND = 2'd3;

  localparam logic [1:0] VPF_NONE     = 2'd0;
  localparam logic [1:0] VPF_RELATIVE = 2'd1;
  localparam logic [1:0] VPF_ENHANCED = 2'd2;

  localparam logic [7:0] VP_LEN_RELATIVE = 8'd1;
  localparam logic [7:0] VP_LEN_ENHANCED = 8'd7;
  localparam logic [7:0] VP_LEN_ABSOLUTE = 8'd10;
  localparam logic [7:0] TS_LEN          = 8'd7;

  typedef struct packed {
    logic [7:0] data_octet;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0] field_tag;
    logic [7:0] field_value;
    logic [7:0] field_index;
    logic [2:0] number_kind;
    logic [3:0] numbering_plan;
    logic [1:0] validity_format;
    logic       message_done;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic [3:0] parse_phase;
    logic [7:0] octet_counter;
    logic [7:0] field_length;
    logic [1:0] saved_validity_format;
    logic       completed;
  } parse_state_t;

endpackage

`default_nettype wire

/* rtl/core/sms_tpdu_field_parser.sv */
// Each result is registered and appears in the cycle after its octet is accepted.
// Throughput: one octet per cycle; input is taken whenever the result
// register is empty or being emptied in the same cycle.
// Reset (synchronous, active high) clears the parse state, empties the
// result register and sets message_kind to deliver.
`default_nettype none

module sms_tpdu_field_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stp_pkg::out_item_t      out_item
);
  import stp_pkg::*;

  `include "assert_macros.svh"

  logic [1:0]   message_kind;
  parse_state_t st;
  parse_state_t st_next;
  out_item_t    res;
  logic         in_fire;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  stp_step u_step (
    .kind    (message_kind),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      message_kind <= KIND_DELIVER;
    end else if (cfg_wr_en) begin
      message_kind <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item <= res;
    end
  end

  `STP_ASSERT_IMP(a_done_not_trunc, out_valid && out_item.message_done,
                  !out_item.truncated)
  `STP_ASSERT_IMP(a_trail_quiet, out_valid && out_item.field_tag == TAG_TRAIL,
                  out_item.field_index == 8'd0 && !out_item.message_done && !out_item.truncated)
  `STP_ASSERT_CLK(a_end_restarts,
                  in_fire && in_item.buffer_end |=> st.parse_phase == PH_HDR && !st.completed)

endmodule

`default_nettype wire

/* rtl/core/stp_step.sv */
`default_nettype none

module stp_step (
  input  wire logic [1:0]           kind,
  input  wire stp_pkg::parse_state_t st,
  input  wire stp_pkg::in_item_t     item,
  output stp_pkg::parse_state_t      st_next,
  output stp_pkg::out_item_t         res
);
  import stp_pkg::*;

  logic [3:0] ph;
  logic [7:0] v;
  logic [8:0] cnt_inc;
  logic       last_digit;
  logic       last_ts;
  logic       last_vl;
  logic       done;

  assign v          = item.data_octet;
  assign cnt_inc    = {1'b0, st.octet_counter} + 9'd1;
  assign last_digit = cnt_inc >= {1'b0, st.field_length};
  assign last_ts    = cnt_inc >= {1'b0, TS_LEN};
  assign last_vl    = last_digit;
  assign ph         = (st.parse_phase > PH_CMD) ? PH_HDR : st.parse_phase;

  always_comb begin
    st_next = st;
    done    = 1'b0;
    res     = '0;
    res.field_tag   = TAG_TRAIL;
    res.field_value = v;
    if (!st.completed) begin
      res.field_tag = ph;
      case (ph)
        PH_HDR: begin
          if (kind == KIND_SUBMIT) begin
            st_next.saved_validity_format = v[4:3];
            res.validity_format           = v[4:3];
          end else begin
            st_next.saved_validity_format = VPF_NONE;
          end
          st_next.parse_phase   = (kind == KIND_DELIVER) ? PH_ALEN : PH_REF;
          st_next.octet_counter = '0;
        end
        PH_REF: begin
          st_next.parse_phase   = (kind == KIND_COMMAND) ? PH_PID : PH_ALEN;
          st_next.octet_counter = '0;
        end
        PH_ALEN: begin
          st_next.octet_counter = '0;
          if (v == 8'd0) begin
            st_next.parse_phase = PH_PID;
          end else begin
            st_next.field_length = v - 8'd1;
            st_next.parse_phase  = PH_ATYPE;
          end
        end
        PH_ATYPE: begin
          res.number_kind       = v[6:4];
          res.numbering_plan    = v[3:0];
          st_next.parse_phase   = (st.field_length == 8'd0) ? PH_PID : PH_DIGITS;
          st_next.octet_counter = '0;
        end
        PH_DIGITS: begin
          res.field_index = st.octet_counter;
          if (last_digit) begin
            st_next.parse_phase   = PH_PID;
            st_next.octet_counter = '0;
          end else begin
            st_next.octet_counter = cnt_inc[7:0];
          end
        end
        PH_PID: begin
          st_next.parse_phase   = PH_DCS;
          st_next.octet_counter = '0;
        end
        PH_DCS: begin
          st_next.octet_counter = '0;
          if (kind == KIND_COMMAND) begin
            st_next.parse_phase = PH_CMD;
          end else if (kind == KIND_SUBMIT) begin
            case (st.saved_validity_format)
              VPF_NONE: begin
                st_next.parse_phase = PH_UDL;
              end
              VPF_RELATIVE: begin
                st_next.parse_phase  = PH_VP;
                st_next.field_length = VP_LEN_RELATIVE;
              end
              VPF_ENHANCED: begin
                st_next.parse_phase  = PH_VP;
                st_next.field_length = VP_LEN_ENHANCED;
              end
              default: begin
                st_next.parse_phase  = PH_VP;
                st_next.field_length = VP_LEN_ABSOLUTE;
              end
            endcase
          end else begin
            st_next.parse_phase = PH_TS;
          end
        end
        PH_TS: begin
          res.field_index = st.octet_counter;
          if (last_ts) begin
            st_next.parse_phase   = (kind == KIND_STATUS) ? PH_STS : PH_UDL;
            st_next.octet_counter = '0;
          end else begin
            st_next.octet_counter = cnt_inc[7:0];
          end
        end
        PH_VP: begin
          res.field_index = st.octet_counter;
          if (last_vl) begin
            st_next.parse_phase   = PH_UDL;
            st_next.octet_counter = '0;
          end else begin
            st_next.octet_counter = cnt_inc[7:0];
          end
        end
        PH_UDL: begin
          if (v == 8'd0) begin
            done = 1'b1;
          end else begin
            st_next.field_length  = v;
            st_next.parse_phase   = PH_UD;
            st_next.octet_counter = '0;
          end
        end
        PH_UD: begin
          res.field_index = st.octet_counter;
          if (last_digit) begin
            done = 1'b1;
          end else begin
            st_next.octet_counter = cnt_inc[7:0];
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        st_next.completed = 1'b1;
      end
      res.message_done = done;
      res.truncated    = item.buffer_end & ~done;
    end
    // end of buffer: next octet opens a new message
    if (item.buffer_end) begin
      st_next = '0;
    end
  end

endmodule

`default_nettype wire
